### rtl/core/ack_retransmit_table_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the retransmit table modules.
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH
`define ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ART_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("retransmit table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ART_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("retransmit table assertion failed");

`endif

### rtl/core/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Field widths, operation and event codes, and the control types shared by
// the retransmit table controller and datapath.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int OP_W       = 2;
	localparam int ID_W       = 16;
	localparam int TIME_W     = 16;
	localparam int TRY_W      = 4;
	localparam int KIND_W     = 3;
	localparam int SLOT_OUT_W = 4;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
	localparam logic [OP_W-1:0] OP_CONFIRM = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	localparam logic [KIND_W-1:0] EV_STORED    = 3'd0;
	localparam logic [KIND_W-1:0] EV_FULL      = 3'd1;
	localparam logic [KIND_W-1:0] EV_CONFIRMED = 3'd2;
	localparam logic [KIND_W-1:0] EV_NOMATCH   = 3'd3;
	localparam logic [KIND_W-1:0] EV_RESEND    = 3'd4;
	localparam logic [KIND_W-1:0] EV_DROPPED   = 3'd5;
	localparam logic [KIND_W-1:0] EV_TICKDONE  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 1'b1;

	localparam logic [TRY_W-1:0]  RETRY_RESET   = 4'd3;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd250;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] remain_ms;
		logic [TRY_W-1:0]  tries;
	} art_slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd_en;
		logic eval_en;
		logic send_en;
		logic final_en;
	} art_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic eval_emit;
		logic eval_match;
		logic out_free;
	} art_sts_t;

endpackage

### rtl/core/art_req_if.sv
// ----------------------------------------------------------------------------
// art_req_if
// Request channel of the retransmit table: operation, message id and
// elapsed time, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface art_req_if import art_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ID_W-1:0]   message_id;
	logic [TIME_W-1:0] elapsed_ms;

	modport source (output valid, output operation, output message_id, output elapsed_ms,
		input ready);
	modport sink (input valid, input operation, input message_id, input elapsed_ms,
		output ready);

endinterface

### rtl/core/art_evt_if.sv
// ----------------------------------------------------------------------------
// art_evt_if
// Event channel of the retransmit table: one or more events per request,
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface art_evt_if import art_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     event_kind;
	logic [ID_W-1:0]       event_id;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  last_of_run;

	modport source (output valid, output event_kind, output event_id, output slot_index,
		output last_of_run, input ready);
	modport sink (input valid, input event_kind, input event_id, input slot_index,
		input last_of_run, output ready);

endinterface

### rtl/core/art_dp.sv
// ----------------------------------------------------------------------------
// art_dp
// Datapath of the retransmit table: configuration registers, request
// register, slot valid bits, slot memory, slot evaluation and event register.
// ----------------------------------------------------------------------------
`include "ack_retransmit_table_core_defines.svh"

module art_dp import art_pkg::*; #(
	parameter int TABLE_SLOTS = 16,
	parameter int IDX_W       = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic [OP_W-1:0]       req_operation,
	input  logic [ID_W-1:0]       req_message_id,
	input  logic [TIME_W-1:0]     req_elapsed_ms,
	input  art_cmd_t              cmd,
	input  logic [IDX_W-1:0]      rd_addr,
	input  logic [IDX_W-1:0]      eval_idx,
	output art_sts_t              sts,
	output logic                  evt_valid,
	input  logic                  evt_ready,
	output logic [KIND_W-1:0]     evt_kind,
	output logic [ID_W-1:0]       evt_id,
	output logic [SLOT_OUT_W-1:0] evt_slot,
	output logic                  evt_last
);

	logic [TRY_W-1:0]       retry_q;
	logic [TIME_W-1:0]      timeout_q;
	logic [OP_W-1:0]        op_q;
	logic [ID_W-1:0]        id_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	art_slot_t              slot_mem [TABLE_SLOTS];
	art_slot_t              rd_data_s1;

	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic                   cur_valid;
	logic                   expired;
	logic                   has_tries;
	logic                   match;
	logic [TIME_W-1:0]      reload;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	art_slot_t              wr_data;
	logic                   emit;
	logic [KIND_W-1:0]      emit_kind;
	logic [ID_W-1:0]        emit_id;
	logic [SLOT_OUT_W-1:0]  emit_slot;
	logic                   emit_last;
	logic                   evt_valid_q;
	logic [KIND_W-1:0]      evt_kind_q;
	logic [ID_W-1:0]        evt_id_q;
	logic [SLOT_OUT_W-1:0]  evt_slot_q;
	logic                   evt_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q   <= RETRY_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RETRY_LIMIT: retry_q   <= cfg_wdata[TRY_W-1:0];
				CFG_TIMEOUT_MS:  timeout_q <= cfg_wdata[TIME_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req_operation;
			id_q      <= req_message_id;
			elapsed_q <= req_elapsed_ms;
		end
	end

	// Lowest free slot for a send.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Evaluation of the slot whose entry is held in the read register rd_data_s1.
	always_comb begin
		cur_valid      = valid_q[eval_idx];
		expired        = cur_valid && (rd_data_s1.remain_ms < elapsed_q);
		has_tries      = (rd_data_s1.tries != '0);
		match          = cur_valid && (rd_data_s1.id == id_q);
		reload         = (timeout_q > elapsed_q) ? (timeout_q - elapsed_q) : '0;
		sts.eval_match = (op_q == OP_CONFIRM) && match;
		sts.eval_emit  = (op_q == OP_TICK) ? expired : sts.eval_match;
		sts.out_free   = !evt_valid_q || evt_ready;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = eval_idx;
		wr_data = rd_data_s1;
		if (cmd.send_en && free_found) begin
			wr_en   = 1'b1;
			wr_addr = free_idx;
			wr_data = '{id: id_q, remain_ms: timeout_q, tries: retry_q};
		end else if (cmd.eval_en && (op_q == OP_TICK) && cur_valid) begin
			if (!expired) begin
				wr_en             = 1'b1;
				wr_data.remain_ms = rd_data_s1.remain_ms - elapsed_q;
			end else if (has_tries) begin
				wr_en             = 1'b1;
				wr_data.remain_ms = reload;
				wr_data.tries     = rd_data_s1.tries - TRY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.send_en && free_found) begin
			valid_q[free_idx] <= 1'b1;
		end else if (cmd.eval_en && ((op_q == OP_TICK && expired && !has_tries) ||
				(op_q == OP_CONFIRM && match))) begin
			valid_q[eval_idx] <= 1'b0;
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_kind = EV_TICKDONE;
		emit_id   = '0;
		emit_slot = '0;
		emit_last = 1'b1;
		priority if (cmd.send_en) begin
			emit      = 1'b1;
			emit_kind = free_found ? EV_STORED : EV_FULL;
			emit_id   = id_q;
			emit_slot = free_found ? SLOT_OUT_W'(free_idx) : '0;
		end else if (cmd.eval_en && sts.eval_emit) begin
			emit      = 1'b1;
			emit_id   = rd_data_s1.id;
			emit_slot = SLOT_OUT_W'(eval_idx);
			if (op_q == OP_CONFIRM) begin
				emit_kind = EV_CONFIRMED;
			end else begin
				emit_kind = has_tries ? EV_RESEND : EV_DROPPED;
				emit_last = 1'b0;
			end
		end else if (cmd.final_en) begin
			emit      = 1'b1;
			emit_kind = (op_q == OP_TICK) ? EV_TICKDONE : EV_NOMATCH;
			emit_id   = (op_q == OP_TICK) ? '0 : id_q;
		end else begin
			emit      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			evt_kind_q <= emit_kind;
			evt_id_q   <= emit_id;
			evt_slot_q <= emit_slot;
			evt_last_q <= emit_last;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt_kind  = evt_kind_q;
	assign evt_id    = evt_id_q;
	assign evt_slot  = evt_slot_q;
	assign evt_last  = evt_last_q;

	`ART_ASSERT_IMP(a_emit_has_room, emit, sts.out_free)
	`ART_ASSERT_NXT(a_send_marks_slot, cmd.send_en && free_found, valid_q[$past(free_idx)])
	`ART_ASSERT_NXT(a_confirm_frees_slot, cmd.eval_en && sts.eval_match, !valid_q[$past(eval_idx)])

endmodule

### rtl/core/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl
// Controller of the retransmit table: request dispatch, the slot sweep
// counter with its one-deep read stage, and event issue under backpressure.
// ----------------------------------------------------------------------------
`include "ack_retransmit_table_core_defines.svh"

module art_ctrl import art_pkg::*; #(
	parameter int TABLE_SLOTS = 16,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [OP_W-1:0]  req_operation,
	output logic             req_ready,
	input  art_sts_t         sts,
	output art_cmd_t         cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] eval_idx
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SEND  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] rd_cnt_d;
	logic             eval_vld_s1;
	logic             eval_vld_d;
	logic [IDX_W-1:0] eval_idx_s1;
	logic [IDX_W-1:0] eval_idx_d;
	logic             more;
	logic             stall;
	logic [2:0]       issue_cmds;
	logic             scan_start;
	logic             scan_clean;
	logic             sweep_done;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		rd_cnt_d   = rd_cnt_q;
		eval_vld_d = eval_vld_s1;
		eval_idx_d = eval_idx_s1;
		more       = (rd_cnt_q != CNT_W'(TABLE_SLOTS));
		// An evaluated slot that has an event to give waits for the event register.
		stall      = eval_vld_s1 && sts.eval_emit && !sts.out_free;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_operation)
						OP_SEND: state_d = ST_SEND;
						OP_CONFIRM, OP_TICK: begin
							state_d    = ST_SCAN;
							rd_cnt_d   = '0;
							eval_vld_d = 1'b0;
						end
						OP_NONE: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEND: begin
				if (sts.out_free) begin
					cmd.send_en = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					cmd.eval_en = eval_vld_s1;
					cmd.rd_en   = more;
					eval_vld_d  = more;
					eval_idx_d  = rd_cnt_q[IDX_W-1:0];
					if (more) begin
						rd_cnt_d = rd_cnt_q + CNT_W'(1);
					end
					// A confirm ends at its first match; the slot read behind it is dropped.
					if (eval_vld_s1 && sts.eval_match) begin
						state_d    = ST_IDLE;
						eval_vld_d = 1'b0;
					end else if (!more) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.final_en = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_cnt_q    <= rd_cnt_d;
			eval_vld_s1 <= eval_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		eval_idx_s1 <= eval_idx_d;
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign rd_addr    = rd_cnt_q[IDX_W-1:0];
	assign eval_idx   = eval_idx_s1;
	assign issue_cmds = {cmd.send_en, cmd.eval_en, cmd.final_en};
	assign scan_start = (state_q == ST_IDLE) && req_valid &&
		(req_operation == OP_CONFIRM || req_operation == OP_TICK);
	assign scan_clean = (state_q == ST_SCAN) && (rd_cnt_q == '0) && !eval_vld_s1;
	assign sweep_done = (rd_cnt_q == CNT_W'(TABLE_SLOTS)) && !eval_vld_s1;

	`ART_ASSERT_IMP(a_one_issue, 1'b1, $onehot0(issue_cmds))
	`ART_ASSERT_NXT(a_scan_starts_clean, scan_start, scan_clean)
	`ART_ASSERT_IMP(a_final_after_sweep, state_q == ST_FINAL, sweep_done)

endmodule

### rtl/core/ack_retransmit_table_core.sv
// ----------------------------------------------------------------------------
// ack_retransmit_table_core
// Table of sent messages awaiting confirmation, with per-slot timeout and
// retry countdown.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready): send registers a message id in the
// lowest free slot, confirm frees the lowest matching slot, tick ages every
// slot by elapsed_ms. Events leave on evt (valid/ready); last_of_run marks
// the final event of each request. cfg_we/cfg_index/cfg_wdata write the retry
// limit (index 0) and the timeout (index 1); the user must write them only
// while no request is in flight, which the block itself does not enforce.
// A send gives its one event at the same edge at which the block is ready
// again. Confirm and tick sweep the slot memory through its single read
// port, one slot per cycle while no event stalls; a confirm is never longer
// than a tick, shorter on a match. Resend and drop events appear during the
// sweep. Reset clears every slot valid bit and loads retry limit 3 and
// timeout 250; no clearing pass is needed. A stalled event receiver halts the
// sweep at the slot that waits to report; the event register lets the block
// accept the next request while the final event is still waiting.
// ----------------------------------------------------------------------------
module ack_retransmit_table_core import art_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	art_req_if.sink              req,
	art_evt_if.source            evt
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	art_cmd_t         cmd;
	art_sts_t         sts;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] eval_idx;

	art_ctrl #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.sts           (sts),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.eval_idx      (eval_idx)
	);

	art_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.IDX_W       (IDX_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.req_operation  (req.operation),
		.req_message_id (req.message_id),
		.req_elapsed_ms (req.elapsed_ms),
		.cmd            (cmd),
		.rd_addr        (rd_addr),
		.eval_idx       (eval_idx),
		.sts            (sts),
		.evt_valid      (evt.valid),
		.evt_ready      (evt.ready),
		.evt_kind       (evt.event_kind),
		.evt_id         (evt.event_id),
		.evt_slot       (evt.slot_index),
		.evt_last       (evt.last_of_run)
	);

endmodule
